>>> design/sta_pkg.sv
// ----------------------------------------------------------------------------
// sta_pkg: shared types and constants of the sorted-table block allocator
// Holds the table entry layout, the cell command set and the register map.
// ----------------------------------------------------------------------------
`default_nettype none
package sta_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int BLOCK_SHIFT_DEF = 7;
  localparam logic [15:0] SIZE_LIMIT = 16'hFFFF;

  localparam logic [1:0] REG_FIT_METHOD    = 2'd0;
  localparam logic [1:0] REG_REGION_START  = 2'd1;
  localparam logic [1:0] REG_REGION_BLOCKS = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] size;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_ROT  = 2'd1,
    CMD_INS  = 2'd2,
    CMD_DEL  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t   cmd;
    entry_t ent;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> design/sta_cell.sv
// ----------------------------------------------------------------------------
// sta_cell: one slot of the allocation table ring
// Holds one entry and takes its neighbor's entry on rotate, insert or delete.
// ----------------------------------------------------------------------------
`default_nettype none
module sta_cell #(
  parameter int N   = sta_pkg::MAX_ENTRIES_DEF,
  parameter int IW  = 8,
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire sta_pkg::cell_ctl_t ctl,
  input  wire logic [IW-1:0]     idx,
  input  wire sta_pkg::entry_t   left,
  input  wire sta_pkg::entry_t   right,
  output sta_pkg::entry_t        q
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam bit IS_LAST = (IDX == N - 1);

  sta_pkg::entry_t q_r, q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (ctl.cmd)
      sta_pkg::CMD_ROT: q_nxt = left;
      sta_pkg::CMD_INS: begin
        if (MY_IDX > idx) q_nxt = left;
        else if (MY_IDX == idx) q_nxt = ctl.ent;
      end
      sta_pkg::CMD_DEL: begin
        // close the gap: pull from above
        if (MY_IDX >= idx && !IS_LAST) q_nxt = right;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
`default_nettype wire

>>> design/sorted_table_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_block_allocator_unit: block allocator over a sorted table
// Places allocations in the best or first fitting gap and frees by address.
// ----------------------------------------------------------------------------
// Every request word passes through these steps in order: acceptance, one
// full rotation of the ring of table cells, in which the entry leaving the
// top cell is examined each cycle from the highest index down, a step for
// the gap at position zero, and a commit step that inserts or deletes the
// entry in all cells at once and loads the result register. No request is
// taken while one is in progress. A finished result waits in the output
// register; commit of the next one holds while it is stalled. The table needs
// no clearing after reset: only entries below the live count are ever used.
// Configuration writes are taken in every cycle.
`default_nettype none
module sorted_table_block_allocator_unit #(
  parameter int MAX_ENTRIES = sta_pkg::MAX_ENTRIES_DEF,
  parameter int BLOCK_SHIFT = sta_pkg::BLOCK_SHIFT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [22:0] in_request_bytes,
  input  wire logic [20:0] in_align_bytes,
  input  wire logic [31:0] in_free_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_ok,
  output logic [31:0]      out_alloc_address,
  output logic [15:0]      out_free_blocks,
  output logic [8:0]       out_entry_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int N  = MAX_ENTRIES;
  localparam int IW = $clog2(N);
  localparam int LW = $clog2(N + 1);
  localparam logic [IW-1:0] TOP_IDX = IW'(N - 1);
  localparam logic [23:0] BLK_M1 = 24'((64'd1 << BLOCK_SHIFT) - 64'd1);
  localparam logic [21:0] BLK_BYTES = 22'(64'd1 << BLOCK_SHIFT);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_FIN  = 5'b00100,
    ST_CMT  = 5'b01000,
    ST_WAIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic        fit_r;
  logic [31:0] region_start_r;
  logic [15:0] region_blocks_r;

  // allocator state
  logic [LW-1:0] live_r, live_nxt;
  logic [15:0]   used_r, used_nxt;

  // request context
  logic          mode_r;
  logic          bad_r;
  logic [15:0]   size_r;
  logic [20:0]   mask_r;
  logic [15:0]   off_r;
  logic [IW-1:0] i_r;
  logic [15:0]   rend_r;
  logic          found_r;
  logic          stop_r;
  logic [15:0]   least_r;
  logic [IW-1:0] idx_r;
  logic [15:0]   pos_r;
  logic [15:0]   selsize_r;

  // output register
  logic        out_valid_r;
  logic        out_ok_r;
  logic [31:0] out_addr_r;
  logic [15:0] out_free_r;
  logic [8:0]  out_cnt_r;

  sta_pkg::entry_t   cells [N];
  sta_pkg::entry_t   tap;
  sta_pkg::cell_ctl_t ctl;
  logic [IW-1:0]     ctl_idx;

  // ---- request decode at accept ----
  logic [23:0] size_sum;
  logic [23:0] size_w;
  logic [20:0] al_m1, smear;
  logic [20:0] mask_w;
  logic [32:0] off_full;
  logic [47:0] region_bytes;
  logic        free_bad;
  logic        accept;

  always_comb begin
    size_sum = {1'b0, in_request_bytes} + BLK_M1;
    size_w   = size_sum >> BLOCK_SHIFT;
    al_m1    = in_align_bytes - 21'd1;
    smear    = al_m1;
    for (int s = 1; s < 32; s = s * 2) begin
      smear = smear | (smear >> s);
    end
    mask_w = ({1'b0, in_align_bytes} > BLK_BYTES) ? (smear >> BLOCK_SHIFT) : 21'd0;
    off_full     = {1'b0, in_free_address} - {1'b0, region_start_r};
    region_bytes = 48'(region_blocks_r) << BLOCK_SHIFT;
    free_bad = off_full[32] || (48'(off_full[31:0]) >= region_bytes) ||
               ((off_full[31:0] & 32'(BLK_M1)) != 32'd0);
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign tap      = cells[N-1];

  // ---- scan step ----
  logic        step_ok;
  logic [21:0] end_w, posr;
  logic signed [23:0] waste;
  logic signed [23:0] waste0;
  logic        better, better0;

  always_comb begin
    step_ok = (LW'(i_r) < live_r) && !stop_r && !bad_r;
    end_w   = 22'(tap.pos) + 22'(tap.size);
    posr    = (end_w + 22'(mask_r)) & ~22'(mask_r);
    waste   = $signed({8'd0, rend_r}) - $signed({2'd0, posr}) - $signed({8'd0, size_r});
    better  = !waste[23] && (!found_r || (waste[15:0] < least_r));
    waste0  = $signed({8'd0, rend_r}) - $signed({8'd0, size_r});
    better0 = !waste0[23] && (!found_r || (waste0[15:0] < least_r));
  end

  // ---- commit ----
  logic        out_busy;
  logic        commit;
  logic [16:0] used_sum;
  logic [31:0] addr_w;
  logic [15:0] free_w;

  always_comb begin
    out_busy = out_valid_r && out_stall;
    commit   = (state_r == ST_CMT) && !out_busy;
    used_sum = {1'b0, used_r} + {1'b0, size_r};
    live_nxt = live_r;
    used_nxt = used_r;
    addr_w   = 32'd0;
    if (commit && found_r) begin
      if (mode_r == sta_pkg::MODE_ALLOC) begin
        live_nxt = live_r + LW'(1);
        used_nxt = used_sum[16] ? sta_pkg::SIZE_LIMIT : used_sum[15:0];
        addr_w   = region_start_r + (32'(pos_r) << BLOCK_SHIFT);
      end else begin
        live_nxt = live_r - LW'(1);
        used_nxt = (used_r >= selsize_r) ? (used_r - selsize_r) : 16'd0;
      end
    end
    free_w = (used_nxt >= region_blocks_r) ? 16'd0 : (region_blocks_r - used_nxt);
  end

  // ---- cell control ----
  always_comb begin
    ctl.cmd = sta_pkg::CMD_HOLD;
    ctl.ent = '{pos: pos_r, size: size_r};
    ctl_idx = idx_r;
    if (state_r == ST_SCAN) begin
      ctl.cmd = sta_pkg::CMD_ROT;
    end else if (commit && found_r) begin
      ctl.cmd = (mode_r == sta_pkg::MODE_ALLOC) ? sta_pkg::CMD_INS : sta_pkg::CMD_DEL;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    sta_cell #(.N(N), .IW(IW), .IDX(k)) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (ctl_idx),
      .left  (cells[(k + N - 1) % N]),
      .right (cells[(k + 1) % N]),
      .q     (cells[k])
    );
  end

  // ---- state machine ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_SCAN;
      ST_SCAN: if (i_r == '0) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_CMT;
      ST_CMT:  if (!out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      fit_r           <= 1'b0;
      region_start_r  <= 32'd0;
      region_blocks_r <= 16'd0;
      live_r          <= '0;
      used_r          <= 16'd0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      live_r  <= live_nxt;
      used_r  <= used_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sta_pkg::REG_FIT_METHOD:    fit_r <= cfg_data[0];
          sta_pkg::REG_REGION_START:  region_start_r <= cfg_data;
          sta_pkg::REG_REGION_BLOCKS: region_blocks_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (commit) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_r  <= in_mode;
          size_r  <= size_w[15:0];
          mask_r  <= mask_w;
          off_r   <= 16'(off_full[31:0] >> BLOCK_SHIFT);
          bad_r   <= (in_mode == sta_pkg::MODE_FREE) ? free_bad :
                     ((size_w > 24'(sta_pkg::SIZE_LIMIT)) || (live_r >= LW'(N)));
          i_r     <= TOP_IDX;
          rend_r  <= region_blocks_r;
          found_r <= 1'b0;
          stop_r  <= 1'b0;
          least_r <= 16'd0;
        end
      end
      ST_SCAN: begin
        i_r <= i_r - IW'(1);
        if (step_ok) begin
          if (mode_r == sta_pkg::MODE_ALLOC) begin
            rend_r <= tap.pos;
            if (better) begin
              found_r <= 1'b1;
              least_r <= waste[15:0];
              idx_r   <= i_r + IW'(1);
              pos_r   <= posr[15:0];
              if (fit_r) stop_r <= 1'b1;
            end
          end else if (tap.pos == off_r) begin
            // keep overwriting: the lowest match arrives last
            found_r   <= 1'b1;
            idx_r     <= i_r;
            selsize_r <= tap.size;
          end
        end
      end
      ST_FIN: begin
        // gap at position zero counts only after a full scan
        if (mode_r == sta_pkg::MODE_ALLOC && !stop_r && !bad_r && better0) begin
          found_r <= 1'b1;
          idx_r   <= '0;
          pos_r   <= 16'd0;
        end
      end
      default: ;
    endcase
    if (commit) begin
      out_ok_r   <= found_r;
      out_addr_r <= addr_w;
      out_free_r <= free_w;
      out_cnt_r  <= 9'(live_nxt);
    end
  end

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_alloc_address = out_addr_r;
  assign out_free_blocks   = out_free_r;
  assign out_entry_count   = out_cnt_r;

endmodule
`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted-table block allocator
// Drives allocate and free words with random gaps and stalls, predicts each
// result from a local copy of the allocation table, and checks every field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;

  localparam int NENT = sta_pkg::MAX_ENTRIES_DEF;
  localparam int BSH  = sta_pkg::BLOCK_SHIFT_DEF;

  typedef struct packed {
    logic        mode;
    logic [22:0] req;
    logic [20:0] align;
    logic [31:0] faddr;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
    logic [15:0] free_blk;
    logic [8:0]  count;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic [22:0] in_request_bytes = '0;
  logic [20:0] in_align_bytes = '0;
  logic [31:0] in_free_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_ok;
  logic [31:0] out_alloc_address;
  logic [15:0] out_free_blocks;
  logic [8:0] out_entry_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #4 clk = ~clk;

  sorted_table_block_allocator_unit dut (.*);

  // predictor state
  logic [15:0] tab_pos [NENT];
  logic [15:0] tab_size [NENT];
  int unsigned live_cnt = 0;
  int unsigned used_cnt = 0;
  logic        fit_first = 1'b0;
  logic [31:0] base_addr = '0;
  logic [15:0] region_len = '0;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  longint unsigned live_addrs[$];
  int errors = 0;
  int out_hold = 0;
  int rx_long = 0;
  bit in_taken = 1'b0;
  bit drain_wait = 1'b0;

  function automatic rsp_t pack_rsp(logic ok, logic [31:0] addr);
    rsp_t r;
    r.ok = ok;
    r.addr = addr;
    r.free_blk = (used_cnt >= region_len) ? 16'd0 : 16'(region_len - used_cnt);
    r.count = 9'(live_cnt);
    return r;
  endfunction

  function automatic longint unsigned rnd_up(longint unsigned x, longint unsigned a);
    return (x + a - 1) / a * a;
  endfunction

  function automatic rsp_t predict_alloc(req_t q);
    longint unsigned size, ab, p, pos;
    longint region_end, least, waste;
    int idx, i;
    size = (longint'(q.req) + (1 << BSH) - 1) >> BSH;
    ab = 1;
    least = 64'sh7FFF_FFFF_FFFF_FFFF;
    idx = -1;
    if (q.align > (1 << BSH)) begin
      p = 1;
      while (p < q.align) p <<= 1;
      ab = p >> BSH;
    end
    if (size > sta_pkg::SIZE_LIMIT || live_cnt >= NENT) return pack_rsp(1'b0, '0);
    region_end = region_len;
    for (i = int'(live_cnt) - 1; i >= 0; i--) begin
      pos = rnd_up(longint'(tab_pos[i]) + tab_size[i], ab);
      waste = region_end - longint'(pos) - longint'(size);
      if (waste >= 0 && waste < least) begin
        idx = i + 1;
        least = waste;
        if (fit_first) break;
      end
      region_end = tab_pos[i];
    end
    if (i < 0) begin
      waste = region_end - longint'(size);
      if (waste >= 0 && waste < least) idx = 0;
    end
    if (idx < 0) return pack_rsp(1'b0, '0);
    pos = (idx > 0) ? rnd_up(longint'(tab_pos[idx-1]) + tab_size[idx-1], ab) : 0;
    for (i = int'(live_cnt); i > idx; i--) begin
      tab_pos[i] = tab_pos[i-1];
      tab_size[i] = tab_size[i-1];
    end
    tab_pos[idx] = pos[15:0];
    tab_size[idx] = size[15:0];
    live_cnt++;
    used_cnt += 32'(size);
    if (used_cnt > sta_pkg::SIZE_LIMIT) used_cnt = 32'(sta_pkg::SIZE_LIMIT);
    return pack_rsp(1'b1, 32'(longint'(base_addr) + (pos << BSH)));
  endfunction

  function automatic rsp_t predict_free(req_t q);
    longint unsigned off;
    int i, k;
    if (q.faddr < base_addr) return pack_rsp(1'b0, '0);
    off = longint'(q.faddr) - base_addr;
    if (off >= (longint'(region_len) << BSH) || off[BSH-1:0] != 0)
      return pack_rsp(1'b0, '0);
    off >>= BSH;
    for (i = 0; i < int'(live_cnt); i++)
      if (tab_pos[i] == off) break;
    if (i >= int'(live_cnt)) return pack_rsp(1'b0, '0);
    used_cnt = (used_cnt >= tab_size[i]) ? used_cnt - tab_size[i] : 0;
    for (k = i + 1; k < int'(live_cnt); k++) begin
      tab_pos[k-1] = tab_pos[k];
      tab_size[k-1] = tab_size[k];
    end
    live_cnt--;
    return pack_rsp(1'b1, '0);
  endfunction

  // driver: one word per handshake, random gap before each
  int gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid) begin
        // drop the word once it was taken at the last rising edge
        if (in_taken) begin
          in_valid <= 1'b0;
          in_taken = 1'b0;
          gap = $urandom_range(0, 11);
        end
      end else if (gap > 0) begin
        gap--;
      end else if (pending_reqs.size() > 0 && !drain_wait) begin
        in_valid <= 1'b1;
        {in_mode, in_request_bytes, in_align_bytes, in_free_address} <= pending_reqs[0];
      end
    end
  end

  // predict on the accepting edge
  always @(posedge clk) begin
    req_t q;
    rsp_t r;
    if (rst_n && in_valid && !in_stall) begin
      in_taken = 1'b1;
      q = pending_reqs.pop_front();
      r = (q.mode == sta_pkg::MODE_FREE) ? predict_free(q) : predict_alloc(q);
      if (q.mode == sta_pkg::MODE_ALLOC && r.ok) live_addrs.insert(live_addrs.size(), r.addr);
      expected_rsps.insert(expected_rsps.size(), r);
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      out_hold = $urandom_range(0, 11);
      got = {out_ok, out_alloc_address, out_free_blocks, out_entry_count};
      if (expected_rsps.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
      end else begin
        want = expected_rsps.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp ok=%0d addr=%h free=%0d cnt=%0d %s",
                     want.ok, want.addr, want.free_blk, want.count,
                     $sformatf("got ok=%0d addr=%h free=%0d cnt=%0d",
                               got.ok, got.addr, got.free_blk, got.count));
        end
      end
    end
  end

  // receiver stall: random wait after each word, long hold-off on request
  always @(negedge clk) begin
    if (rx_long > 0) begin
      rx_long--;
      out_stall <= 1'b1;
    end else if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sta_pkg::REG_FIT_METHOD:    fit_first = val[0];
      sta_pkg::REG_REGION_START:  base_addr = val;
      sta_pkg::REG_REGION_BLOCKS: region_len = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void push_req(logic mode, logic [22:0] rq, logic [20:0] al,
                                   logic [31:0] fa);
    req_t q;
    q = {mode, rq, al, fa};
    pending_reqs.insert(pending_reqs.size(), q);
  endfunction

  function automatic logic [31:0] pick_free_addr();
    int k;
    longint unsigned a;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return base_addr + ($urandom_range(0, 200) << BSH) + $urandom_range(1, 127);
      2: return base_addr + ($urandom_range(0, 300) << BSH);
      default: begin
        if (live_addrs.size() == 0) return base_addr;
        k = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[k];
        live_addrs.delete(k);
        return a[31:0];
      end
    endcase
  endfunction

  function automatic logic [20:0] pick_align();
    case ($urandom_range(0, 5))
      0: return 21'($urandom());
      1: return 21'(1 << $urandom_range(0, 20));
      default: return 21'(1 << $urandom_range(0, 10));
    endcase
  endfunction

  function automatic logic [22:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 23'($urandom());
      1: return 23'd0;
      default: return 23'($urandom_range(1, 4000));
    endcase
  endfunction

  task automatic random_phase(int n);
    repeat (n) begin
      if ($urandom_range(0, 9) < 6)
        push_req(sta_pkg::MODE_ALLOC, pick_size(), pick_align(), $urandom());
      else
        push_req(sta_pkg::MODE_FREE, 23'($urandom()), 21'($urandom()), pick_free_addr());
      // free addresses track the predictor only roughly; queue slowly
      while (pending_reqs.size() > 4) @(posedge clk);
    end
  endtask

  initial begin
    int cnt;
    longint unsigned fa;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, both modes, odd alignment, oversize, zero size
    write_reg(sta_pkg::REG_REGION_BLOCKS, 32'd64);
    write_reg(sta_pkg::REG_REGION_START, 32'h0000_1000);
    write_reg(sta_pkg::REG_FIT_METHOD, 32'd0);
    push_req(sta_pkg::MODE_ALLOC, 23'd0, 21'd0, 32'd0);
    push_req(sta_pkg::MODE_ALLOC, 23'h7FFFFF, 21'd0, 32'hFFFF_FFFF);
    push_req(sta_pkg::MODE_ALLOC, 23'd8388480, 21'd0, 32'd0);
    push_req(sta_pkg::MODE_ALLOC, 23'd1, 21'h1FFFFF, 32'd0);
    push_req(sta_pkg::MODE_ALLOC, 23'd200, 21'd384, 32'd0);
    push_req(sta_pkg::MODE_ALLOC, 23'd129, 21'd1024, 32'd0);
    push_req(sta_pkg::MODE_FREE, 23'd0, 21'd0, 32'h0000_1000);
    push_req(sta_pkg::MODE_FREE, 23'd0, 21'd0, 32'h0000_1000);
    push_req(sta_pkg::MODE_FREE, 23'd0, 21'd0, 32'h0000_1001);
    push_req(sta_pkg::MODE_FREE, 23'd0, 21'd0, 32'hFFFF_FFFF);
    push_req(sta_pkg::MODE_FREE, 23'd0, 21'd0, 32'd0);
    push_req(sta_pkg::MODE_ALLOC, 23'd8192, 21'd128, 32'd0);
    push_req(sta_pkg::MODE_ALLOC, 23'd300, 21'd256, 32'd0);
    wait_idle();

    // first fit, high base, wrap of address; fill table with one-block and zero-size words
    write_reg(sta_pkg::REG_FIT_METHOD, 32'd1);
    write_reg(sta_pkg::REG_REGION_START, 32'hFFFF_FF00);
    write_reg(sta_pkg::REG_REGION_BLOCKS, 32'd65535);
    cnt = 0;
    repeat (260) begin
      push_req(sta_pkg::MODE_ALLOC, (cnt % 2) ? 23'd0 : 23'd128, 21'd0, 32'd0);
      cnt++;
      // receiver holds off a long stretch while the sender keeps going
      if (cnt == 5) rx_long = 3000;
    end
    random_phase(20);
    wait_idle();
    // drain the table with frees of every placed entry
    for (int b = 0; b < 300; b++) begin
      if (live_addrs.size() > 0) fa = live_addrs.pop_front();
      else fa = 64'(32'hFFFF_FF00 + 32'(b << BSH));
      push_req(sta_pkg::MODE_FREE, 23'd0, 21'd0, fa[31:0]);
      while (pending_reqs.size() > 4) @(posedge clk);
    end
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(sta_pkg::REG_FIT_METHOD, 32'(ph & 1));
      write_reg(sta_pkg::REG_REGION_START,
                (ph == 2) ? 32'd0 : ($urandom() & 32'hFFFF_FF80));
      write_reg(sta_pkg::REG_REGION_BLOCKS,
                (ph == 3) ? 32'd0 : 32'($urandom_range(16, 800)));
      live_addrs.delete();
      random_phase(140);
      // sender pauses until every result is back
      drain_wait = 1'b1;
      while (expected_rsps.size() > 0 || in_valid) @(posedge clk);
      drain_wait = 1'b0;
      wait_idle();
    end

    wait_idle();
    if (errors == 0 && expected_rsps.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #40000000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
design/sta_pkg.sv
design/sta_cell.sv
design/sorted_table_block_allocator_unit.sv
verif/tb.sv
